FILE: rtl/pae_pkg.sv
package pae_pkg;

   // Bank size default and fixed-point constants.
   localparam int unsigned VOICES_DEFAULT = 128;
   localparam logic [15:0] ONE_Q15        = 16'h8000;
   localparam logic [6:0]  PEDAL_HOLD     = 7'd64;

   localparam logic [15:0] ATTACK_STEP_RESET   = 16'd64;
   localparam logic [15:0] DECAY_STEP_RESET    = 16'd64;
   localparam logic [15:0] SUSTAIN_LEVEL_RESET = 16'd16384;
   localparam logic [15:0] RELEASE_STEP_RESET  = 16'd64;

   typedef enum logic [1:0] {
      REQ_NOTE_ON  = 2'd0,
      REQ_NOTE_OFF = 2'd1,
      REQ_PEDAL    = 2'd2,
      REQ_TICK     = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      STAGE_IDLE    = 3'd0,
      STAGE_ATTACK  = 3'd1,
      STAGE_DECAY   = 3'd2,
      STAGE_SUSTAIN = 3'd3,
      STAGE_RELEASE = 3'd4
   } stage_type;

   typedef enum logic [1:0] {
      CSR_ATTACK_STEP   = 2'd0,
      CSR_DECAY_STEP    = 2'd1,
      CSR_SUSTAIN_LEVEL = 2'd2,
      CSR_RELEASE_STEP  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FSM_IDLE  = 2'd0,
      FSM_EXEC  = 2'd1,
      FSM_WALK  = 2'd2,
      FSM_FETCH = 2'd3
   } fsm_type;

   typedef struct packed {
      req_code_type      req_type;
      logic [6:0]        key;
      logic signed [7:0] amount;
   } req_word_type;

   typedef struct packed {
      logic [15:0] env_level;
      stage_type   env_stage;
      logic [6:0]  voice_velocity;
   } rsp_word_type;

   typedef struct packed {
      stage_type   stage;
      logic [15:0] level;
      logic [6:0]  vel;
      logic        down;
   } voice_type;

   typedef struct packed {
      logic [15:0] attack_step;
      logic [15:0] decay_step;
      logic [15:0] sustain_level;
      logic [15:0] release_step;
   } env_cfg_type;

   typedef struct packed {
      req_code_type op;
      logic         pedal_hold;
      logic         vel_keep;
      logic [6:0]   vel;
   } step_ctrl_type;

endpackage

FILE: rtl/pae_step_unit.sv
// Shared update unit: one add/subtract and its level compares applied to one voice entry.
module pae_step_unit (
   input  pae_pkg::voice_type     cur,
   input  pae_pkg::step_ctrl_type ctrl,
   input  pae_pkg::env_cfg_type   cfg,
   output pae_pkg::voice_type     nxt
);

   logic [15:0] sus;
   logic [15:0] step;
   logic        add_mode;
   logic [16:0] op_b;
   logic [16:0] res;
   logic        above_step;
   logic [15:0] dec_level;

   always_comb begin
      sus = (cfg.sustain_level > pae_pkg::ONE_Q15) ? pae_pkg::ONE_Q15 : cfg.sustain_level;

      case (cur.stage)
         pae_pkg::STAGE_ATTACK: step = cfg.attack_step;
         pae_pkg::STAGE_DECAY:  step = cfg.decay_step;
         default:               step = cfg.release_step;
      endcase

      // The adder subtracts through the inverted operand and a carry in.
      add_mode   = (cur.stage == pae_pkg::STAGE_ATTACK);
      op_b       = add_mode ? {1'b0, step} : ~{1'b0, step};
      res        = {1'b0, cur.level} + op_b + {16'd0, ~add_mode};
      above_step = ~res[16] && (res[15:0] != 16'd0);
      dec_level  = above_step ? res[15:0] : 16'd0;

      nxt = cur;
      unique case (ctrl.op)
         pae_pkg::REQ_NOTE_ON: begin
            nxt.stage = pae_pkg::STAGE_ATTACK;
            nxt.down  = 1'b1;
            if (!ctrl.vel_keep) begin
               nxt.vel = ctrl.vel;
            end
         end
         pae_pkg::REQ_NOTE_OFF: begin
            nxt.down = 1'b0;
            if (!ctrl.pedal_hold) begin
               nxt.stage = pae_pkg::STAGE_RELEASE;
            end
         end
         pae_pkg::REQ_PEDAL: begin
            if (cur.stage != pae_pkg::STAGE_IDLE && !cur.down && !ctrl.pedal_hold) begin
               nxt.stage = pae_pkg::STAGE_RELEASE;
            end
         end
         pae_pkg::REQ_TICK: begin
            case (cur.stage)
               pae_pkg::STAGE_ATTACK: begin
                  if (res[16] || res[15]) begin
                     nxt.level = pae_pkg::ONE_Q15;
                     nxt.stage = pae_pkg::STAGE_DECAY;
                  end else begin
                     nxt.level = res[15:0];
                  end
               end
               pae_pkg::STAGE_DECAY: begin
                  if (dec_level < sus) begin
                     nxt.level = sus;
                     nxt.stage = pae_pkg::STAGE_SUSTAIN;
                  end else begin
                     nxt.level = dec_level;
                  end
               end
               pae_pkg::STAGE_RELEASE: begin
                  nxt.level = dec_level;
                  if (!above_step) begin
                     nxt.stage = pae_pkg::STAGE_IDLE;
                  end
               end
               default: begin
                  nxt.level = cur.level;
               end
            endcase
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

FILE: rtl/poly_adsr_envelope_bank_unit.sv
// Bank of VOICES linear ADSR envelopes sharing one attack, decay, sustain and release
// setting. A request word is taken at a clock edge where start is high and busy is low;
// every request produces exactly one result word, shown for a single cycle with
// rsp_strobe high, and the receiver must take it then because it cannot stall the block.
// Note on, note off and tick requests read the voice entry from the single-port-read
// voice memory, then update it through the shared step unit and write it back. A
// pedal request that lifts the pedal below 64 sweeps every voice through the same
// memory port and step unit, one voice per cycle, then rereads the addressed voice; a
// pedal request at 64 or more reads only that voice. The result word follows the
// last cycle of its request. Voice entries that were never written since reset read as
// idle, level zero, velocity zero, key up, through a valid bit per entry, so no clearing
// pass is needed after reset. Settings registers should only be written while busy is low.
module poly_adsr_envelope_bank_unit #(
   parameter int unsigned VOICES = pae_pkg::VOICES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pae_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output pae_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   localparam int unsigned AW = (VOICES > 1) ? $clog2(VOICES) : 1;

   pae_pkg::fsm_type       state_ff, state_in;
   pae_pkg::req_word_type  req_ff, req_in;
   pae_pkg::env_cfg_type   cfg_ff;
   logic [6:0]             pedal_ff, pedal_in;
   logic [AW-1:0]          walk_idx_ff, walk_idx_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   pae_pkg::rsp_word_type  rsp_word_ff, rsp_word_in;

   // Voice memory with one write and one registered read per cycle.
   pae_pkg::voice_type     voice_mem [VOICES];
   logic [VOICES-1:0]      valid_ff;
   pae_pkg::voice_type     rd_data_ff;
   logic                   rd_valid_ff;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;

   pae_pkg::voice_type     cur;
   pae_pkg::voice_type     nxt;
   pae_pkg::step_ctrl_type ctrl;

   logic [8:0]             new_key_ext;
   logic [8:0]             cur_key_ext;
   logic [AW-1:0]          new_key_addr;
   logic [AW-1:0]          cur_key_addr;
   logic                   cur_in_bank;
   logic [6:0]             pedal_new;
   logic                   walk_last;

   assign busy       = (state_ff != pae_pkg::FSM_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   assign new_key_ext  = {2'b00, req_word.key};
   assign cur_key_ext  = {2'b00, req_ff.key};
   assign new_key_addr = new_key_ext[AW-1:0];
   assign cur_key_addr = cur_key_ext[AW-1:0];
   assign cur_in_bank  = (cur_key_ext < 9'(VOICES));
   assign walk_last    = (walk_idx_ff == AW'(VOICES - 1));

   // A negative pedal position counts as fully up.
   assign pedal_new = req_word.amount[7] ? 7'd0 : req_word.amount[6:0];

   // A voice never written since reset reads as all zero, which is idle.
   assign cur = rd_valid_ff ? rd_data_ff : '0;

   assign ctrl.op         = (state_ff == pae_pkg::FSM_WALK) ? pae_pkg::REQ_PEDAL
                                                            : req_ff.req_type;
   assign ctrl.pedal_hold = (pedal_ff >= pae_pkg::PEDAL_HOLD);
   assign ctrl.vel_keep   = req_ff.amount[7];
   assign ctrl.vel        = req_ff.amount[6:0];

   pae_step_unit u_step (
      .cur  (cur),
      .ctrl (ctrl),
      .cfg  (cfg_ff),
      .nxt  (nxt)
   );

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      pedal_in      = pedal_ff;
      walk_idx_in   = walk_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      rd_en         = 1'b0;
      rd_addr       = new_key_addr;
      wr_en         = 1'b0;
      wr_addr       = cur_key_addr;

      unique case (state_ff)
         pae_pkg::FSM_IDLE: begin
            if (start) begin
               req_in = req_word;
               rd_en  = 1'b1;
               if (req_word.req_type == pae_pkg::REQ_PEDAL) begin
                  pedal_in = pedal_new;
               end
               if (req_word.req_type == pae_pkg::REQ_PEDAL &&
                   pedal_new < pae_pkg::PEDAL_HOLD) begin
                  // Pedal lifted: sweep the whole bank starting at voice zero.
                  rd_addr     = '0;
                  walk_idx_in = '0;
                  state_in    = pae_pkg::FSM_WALK;
               end else begin
                  state_in = pae_pkg::FSM_EXEC;
               end
            end
         end
         pae_pkg::FSM_WALK: begin
            wr_en   = 1'b1;
            wr_addr = walk_idx_ff;
            if (walk_last) begin
               state_in = pae_pkg::FSM_FETCH;
            end else begin
               rd_en       = 1'b1;
               rd_addr     = walk_idx_ff + AW'(1);
               walk_idx_in = walk_idx_ff + AW'(1);
            end
         end
         pae_pkg::FSM_FETCH: begin
            // The last sweep write has landed, so the addressed voice reads fresh.
            rd_en    = 1'b1;
            rd_addr  = cur_key_addr;
            state_in = pae_pkg::FSM_EXEC;
         end
         pae_pkg::FSM_EXEC: begin
            if (cur_in_bank && req_ff.req_type != pae_pkg::REQ_PEDAL) begin
               wr_en = 1'b1;
            end
            rsp_strobe_in = 1'b1;
            if (!cur_in_bank) begin
               rsp_word_in = '0;
            end else if (req_ff.req_type == pae_pkg::REQ_PEDAL) begin
               rsp_word_in.env_level      = cur.level;
               rsp_word_in.env_stage      = cur.stage;
               rsp_word_in.voice_velocity = cur.vel;
            end else begin
               rsp_word_in.env_level      = nxt.level;
               rsp_word_in.env_stage      = nxt.stage;
               rsp_word_in.voice_velocity = nxt.vel;
            end
            state_in = pae_pkg::FSM_IDLE;
         end
         default: begin
            state_in = pae_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pae_pkg::FSM_IDLE;
         pedal_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pedal_ff      <= pedal_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      walk_idx_ff <= walk_idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Settings registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_step   <= pae_pkg::ATTACK_STEP_RESET;
         cfg_ff.decay_step    <= pae_pkg::DECAY_STEP_RESET;
         cfg_ff.sustain_level <= pae_pkg::SUSTAIN_LEVEL_RESET;
         cfg_ff.release_step  <= pae_pkg::RELEASE_STEP_RESET;
      end else if (csr_we) begin
         unique case (pae_pkg::csr_index_type'(csr_index))
            pae_pkg::CSR_ATTACK_STEP:   cfg_ff.attack_step   <= csr_wdata;
            pae_pkg::CSR_DECAY_STEP:    cfg_ff.decay_step    <= csr_wdata;
            pae_pkg::CSR_SUSTAIN_LEVEL: cfg_ff.sustain_level <= csr_wdata;
            pae_pkg::CSR_RELEASE_STEP:  cfg_ff.release_step  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Entry valid bits stand in for clearing the memory after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         voice_mem[wr_addr] <= nxt;
      end
      if (rd_en) begin
         rd_data_ff  <= voice_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

endmodule

FILE: rtl/pae_checker.sv
// Port-level checks on the envelope bank.
module pae_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input pae_pkg::req_word_type req_word,
   input logic                  rsp_strobe,
   input pae_pkg::rsp_word_type rsp_word
);

   // Every accepted word makes the block busy in the cycle after acceptance.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after accepting a word");

   // A note or tick word yields its result after the execute state, through the registered result strobe.
   a_short_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_word.req_type != pae_pkg::REQ_PEDAL |=> ##1 rsp_strobe)
      else $error("missing result for a note or tick word");

   // Results never come in consecutive cycles since every accepted word passes through the execute state.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // Levels never exceed full scale.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_word.env_level <= pae_pkg::ONE_Q15)
      else $error("envelope level above full scale");

   // Coming out of reset the block is idle and shows no result.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !busy && !rsp_strobe)
      else $error("block active right after reset");

endmodule

bind poly_adsr_envelope_bank_unit pae_checker u_pae_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
